// ===== hw/rtl/scba_pkg.sv =====
// Package for the size-class block allocator: codes, types, widths and helpers.
// No dependencies.
package scba_pkg;

  localparam int unsigned NumClasses   = 4;
  localparam int unsigned MaxBlocks    = 4096;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned ReqW         = 32;
  localparam int unsigned AddrW        = 35;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned ClassW       = 2;
  localparam int unsigned RegW         = 13;
  localparam int unsigned CfgIdxW      = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_NOT_IN_POOL = 3'd3,
    ST_KEPT        = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_PUSH
  } bk_state_e;

  // Request and response transfers.
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ReqW-1:0]  request_bytes;
    logic [AddrW-1:0] old_address;
  } alloc_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   address;
    logic [ClassW-1:0]  size_class;
  } alloc_rsp_t;

  // Block size shift of each class.
  function automatic logic [4:0] cls_shift(input logic [ClassW-1:0] c);
    logic [4:0] s;
    unique case (c)
      2'd0:    s = 5'd10;
      2'd1:    s = 5'd14;
      2'd2:    s = 5'd18;
      default: s = 5'd22;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/scba_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing.
interface scba_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/size_class_block_allocator.sv =====
// Top level of the size-class block allocator.
// Depends on scba_pkg, scba_if, scba_front, scba_back.
//
// Channels: req (sink) carries cmd, request_bytes, old_address; rsp (source)
// carries status, address, size_class. A transfer happens when valid and
// ready are both high at a rising edge. Every request gives one response.
// Configuration: cfg_we_i writes cfg_wdata_i to pool size register cfg_idx_i
// (0 1 KiB, 1 16 KiB, 2 256 KiB, 3 4 MiB); write only while idle.
// Path: the request is registered in stage 0, classified into q, then taken
// by the back end, which registers the result; a stack pop adds the BK_READ
// state for the RAM read, and a reallocate that frees its old block adds BK_PUSH.
// Throughput: one item per cycle when no stack read or push is needed and the
// receiver takes results; pops and moves busy the single-port stack RAM.
// Reset clears pool sizes, stack depths and bump counters; the stack RAM
// needs no clearing as entries are read only below their depth.
// A stalled receiver holds the result; the front keeps taking and
// classifying up to two items meanwhile.
module size_class_block_allocator import scba_pkg::*; #(
  parameter int unsigned MaxBlocksPerClass = MaxBlocks
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_wdata_i,
  scba_if.sink               req,
  scba_if.source             rsp
);
  localparam int unsigned CapW = $clog2(MaxBlocksPerClass + 1);

  logic [RegW-1:0]  reg_q [NumClasses];
  logic [CapW-1:0]  cap   [NumClasses];
  logic [AddrW-1:0] base  [NumClasses];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumClasses; c++) reg_q[c] <= '0;
    end else if (cfg_we_i) begin
      reg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Capacity clamps, pool bases: constant between writes.
  always_comb begin
    logic [AddrW-1:0] acc;
    acc = '0;
    for (int c = 0; c < NumClasses; c++) begin
      if (32'(reg_q[c]) > MaxBlocksPerClass) cap[c] = CapW'(MaxBlocksPerClass);
      else cap[c] = CapW'(reg_q[c]);
      base[c] = acc;
      acc = acc + (AddrW'(cap[c]) << cls_shift(ClassW'(c)));
    end
  end

  logic              q_valid, q_ready;
  logic [CmdW-1:0]   q_cmd;
  logic [2:0]        q_rc, q_oc;
  logic [AddrW-1:0]  q_old;

  scba_front #(.CapW(CapW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .cmd_i(req.data.cmd), .req_i(req.data.request_bytes),
    .old_i(req.data.old_address),
    .cap_i(cap), .base_i(base),
    .q_valid_o(q_valid), .q_ready_i(q_ready),
    .q_cmd_o(q_cmd), .q_rc_o(q_rc), .q_oc_o(q_oc), .q_old_o(q_old)
  );

  scba_back #(.MaxBlk(MaxBlocksPerClass), .CapW(CapW)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_cmd_i(q_cmd), .q_rc_i(q_rc), .q_oc_i(q_oc), .q_old_i(q_old),
    .cap_i(cap), .base_i(base),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .status_o(rsp.data.status), .address_o(rsp.data.address),
    .size_class_o(rsp.data.size_class)
  );
endmodule

// ===== hw/rtl/scba_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module scba_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== hw/rtl/scba_front.sv =====
// Front end: registers the request, classifies it by size and by address range.
// Depends on scba_pkg.
module scba_front import scba_pkg::*; #(
  parameter int unsigned CapW = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CmdW-1:0]       cmd_i,
  input  logic [ReqW-1:0]       req_i,
  input  logic [AddrW-1:0]      old_i,
  input  logic [CapW-1:0]       cap_i [NumClasses],
  input  logic [AddrW-1:0]      base_i [NumClasses],
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output logic [CmdW-1:0]       q_cmd_o,
  output logic [2:0]            q_rc_o,   // [2] set: too large
  output logic [2:0]            q_oc_o,   // [2] set: in no pool
  output logic [AddrW-1:0]      q_old_o
);
  // Stage 0 holds the raw item; the classified item then goes to q.
  logic                 s0_valid_q;
  logic [CmdW-1:0]      s0_cmd_q;
  logic [ReqW-1:0]      s0_req_q;
  logic [AddrW-1:0]     s0_old_q;
  logic [2:0]           rc_d, oc_d;
  logic                 q_valid_q;
  logic [CmdW-1:0]      q_cmd_q;
  logic [2:0]           q_rc_q, q_oc_q;
  logic [AddrW-1:0]     q_old_q;
  logic                 s0_adv;

  assign s0_adv     = s0_valid_q && (!q_valid_q || q_ready_i);
  assign in_ready_o = !s0_valid_q || s0_adv;

  always_comb begin
    logic [AddrW:0] lim;
    rc_d = 3'd4;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if ({1'b0, s0_req_q} <= (33'd1 << cls_shift(ClassW'(c)))) begin
        rc_d = 3'(c);
      end
    end
    oc_d = 3'd4;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      lim = {1'b0, base_i[c]} + ((AddrW+1)'(cap_i[c]) << cls_shift(ClassW'(c)));
      if (s0_old_q >= base_i[c] && {1'b0, s0_old_q} < lim) begin
        oc_d = 3'(c);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      q_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) s0_valid_q <= in_valid_i;
      if (s0_adv) q_valid_q <= 1'b1;
      else if (q_ready_i) q_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_cmd_q <= cmd_i;
      s0_req_q <= req_i;
      s0_old_q <= old_i;
    end
    if (s0_adv) begin
      q_cmd_q <= s0_cmd_q;
      q_rc_q  <= rc_d;
      q_oc_q  <= oc_d;
      q_old_q <= s0_old_q;
    end
  end

  assign q_valid_o = q_valid_q;
  assign q_cmd_o   = q_cmd_q;
  assign q_rc_o    = q_rc_q;
  assign q_oc_o    = q_oc_q;
  assign q_old_o   = q_old_q;
endmodule

// ===== hw/rtl/scba_back.sv =====
// Back end: stack/bump bookkeeping on the shared free-stack RAM, result register.
// Depends on scba_pkg and scba_ram.
module scba_back import scba_pkg::*; #(
  parameter int unsigned MaxBlk = 4096,
  parameter int unsigned CapW   = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  logic [CmdW-1:0]       q_cmd_i,
  input  logic [2:0]            q_rc_i,
  input  logic [2:0]            q_oc_i,
  input  logic [AddrW-1:0]      q_old_i,
  input  logic [CapW-1:0]       cap_i [NumClasses],
  input  logic [AddrW-1:0]      base_i [NumClasses],
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [StatusW-1:0]    status_o,
  output logic [AddrW-1:0]      address_o,
  output logic [ClassW-1:0]     size_class_o
);
  localparam int unsigned IdxW = (MaxBlk > 1) ? $clog2(MaxBlk) : 1;
  localparam int unsigned RamD = NumClasses * MaxBlk;
  localparam int unsigned RamA = $clog2(RamD);

  bk_state_e state_q, state_d;
  logic [CapW-1:0] depth_q [NumClasses];
  logic [CapW-1:0] bump_q  [NumClasses];
  logic [CapW-1:0] depth_d [NumClasses];
  logic [CapW-1:0] bump_d  [NumClasses];
  logic            ov_q, ov_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [AddrW-1:0] ad_q, ad_d;
  logic [ClassW-1:0] cl_q, cl_d;
  // Held item context across the stack read.
  logic [ClassW-1:0] hc_q, hc_d;       // class popped
  logic              hf_q, hf_d;       // push old block after pop
  logic [ClassW-1:0] fc_q, fc_d;       // class to push
  logic [IdxW-1:0]   fi_q, fi_d;       // index to push
  logic              we;
  logic [RamA-1:0]   ra;
  logic [IdxW-1:0]   wd, rd;
  logic              take;

  scba_ram #(.Width(IdxW), .Depth(RamD)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(ra), .wdata_i(wd), .rdata_o(rd)
  );

  function automatic logic [IdxW-1:0] idx_of(input logic [AddrW-1:0] a,
                                             input logic [AddrW-1:0] b,
                                             input logic [ClassW-1:0] c);
    logic [AddrW-1:0] d;
    d = (a - b) >> cls_shift(c);
    return d[IdxW-1:0];
  endfunction

  function automatic logic [RamA-1:0] slot(input logic [ClassW-1:0] c,
                                           input logic [CapW-1:0] p);
    return RamA'(c) * RamA'(MaxBlk) + RamA'(p);
  endfunction

  assign take = q_valid_i && state_q == BK_IDLE && (!ov_q || out_ready_i);
  assign q_ready_o = take;

  always_comb begin
    logic [ClassW-1:0] rc, oc;
    logic              alloc, rne, one;
    state_d = state_q;
    depth_d = depth_q;
    bump_d  = bump_q;
    ov_d = ov_q && !out_ready_i;
    st_d = st_q; ad_d = ad_q; cl_d = cl_q;
    hc_d = hc_q; hf_d = hf_q; fc_d = fc_q; fi_d = fi_q;
    we = 1'b0; ra = '0; wd = fi_q;
    rc = q_rc_i[ClassW-1:0];
    oc = q_oc_i[ClassW-1:0];
    alloc = 1'b0; rne = 1'b0; one = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          one = 1'b1;
          st_d = ST_OK; ad_d = '0; cl_d = '0;
          fc_d = oc;
          fi_d = idx_of(q_old_i, base_i[oc], oc);
          unique case (cmd_e'(q_cmd_i))
            CMD_ALLOC, CMD_REALLOC: begin
              rne = (cmd_e'(q_cmd_i) == CMD_REALLOC) && !q_oc_i[2];
              if (q_rc_i[2]) begin
                st_d = ST_TOO_LARGE;
              end else if (rne && oc == rc) begin
                st_d = ST_KEPT; cl_d = rc;
                ad_d = base_i[oc] + ((q_old_i - base_i[oc]) >> cls_shift(oc)
                                     << cls_shift(oc));
              end else begin
                cl_d = rc;
                alloc = 1'b1;
              end
            end
            CMD_FREE: begin
              if (q_oc_i[2]) begin
                st_d = ST_NOT_IN_POOL;
              end else begin
                cl_d = oc;
                ad_d = base_i[oc] + (AddrW'(fi_d) << cls_shift(oc));
                if (depth_q[oc] < CapW'(MaxBlk)) begin
                  we = 1'b1; ra = slot(oc, depth_q[oc]); wd = fi_d;
                  depth_d[oc] = depth_q[oc] + 1'b1;
                end
              end
            end
            default: ;
          endcase
          if (alloc) begin
            if (depth_q[rc] != '0) begin
              depth_d[rc] = depth_q[rc] - 1'b1;
              ra = slot(rc, depth_d[rc]);
              hc_d = rc; hf_d = rne;
              state_d = BK_READ;
              one = 1'b0;
            end else if ({1'b0, bump_q[rc]} < {1'b0, cap_i[rc]}) begin
              ad_d = base_i[rc] + (AddrW'(bump_q[rc][IdxW-1:0]) << cls_shift(rc));
              bump_d[rc] = bump_q[rc] + 1'b1;
              if (rne) begin
                state_d = BK_PUSH;
                one = 1'b0;
              end
            end else begin
              st_d = ST_FULL;
            end
          end
          if (one) ov_d = 1'b1;
        end
      end
      BK_READ: begin
        ad_d = base_i[hc_q] + (AddrW'(rd) << cls_shift(hc_q));
        if (hf_q) begin
          state_d = BK_PUSH;
        end else begin
          ov_d = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_PUSH: begin
        if (depth_q[fc_q] < CapW'(MaxBlk)) begin
          we = 1'b1; ra = slot(fc_q, depth_q[fc_q]); wd = fi_q;
          depth_d[fc_q] = depth_q[fc_q] + 1'b1;
        end
        ov_d = 1'b1;
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
      for (int c = 0; c < NumClasses; c++) begin
        depth_q[c] <= '0;
        bump_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      depth_q <= depth_d;
      bump_q  <= bump_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d; ad_q <= ad_d; cl_q <= cl_d;
    hc_q <= hc_d; hf_q <= hf_d; fc_q <= fc_d; fi_q <= fi_d;
  end

  assign out_valid_o  = ov_q;
  assign status_o     = st_q;
  assign address_o    = ad_q;
  assign size_class_o = cl_q;
endmodule

// ===== bench/size_class_block_allocator_tb.sv =====
// Self-checking bench for the size-class block allocator.
// Depends on scba_pkg, scba_if and size_class_block_allocator.
`timescale 1ns / 100ps

module size_class_block_allocator_tb;
  import scba_pkg::*;

  localparam int unsigned NoClass   = 4;
  localparam int unsigned StallMax  = 20000;
  localparam int unsigned DrainWait = 12;
  localparam int unsigned ShiftOf [NumClasses] = '{10, 14, 18, 22};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_wdata_i = '0;

  scba_if #(.payload_t(alloc_req_t)) req_ch ();
  scba_if #(.payload_t(alloc_rsp_t)) rsp_ch ();

  size_class_block_allocator i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // Allocator shadow state
  logic [RegW-1:0]  pool_blocks [NumClasses];
  logic [11:0]      freed_idx   [NumClasses*MaxBlocks];
  int unsigned      freed_cnt   [NumClasses];
  int unsigned      bump_idx    [NumClasses];
  logic [AddrW-1:0] granted_q   [$];

  alloc_req_t pending_q  [$];
  alloc_rsp_t expected_q [$];

  int unsigned sender_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  function automatic longint unsigned pool_cap(int unsigned c);
    return (pool_blocks[c] > MaxBlocks) ? MaxBlocks : pool_blocks[c];
  endfunction

  function automatic longint unsigned pool_base(int unsigned c);
    longint unsigned b;
    b = 0;
    for (int unsigned k = 0; k < c; k++) b += pool_cap(k) << ShiftOf[k];
    return b;
  endfunction

  function automatic int unsigned fit_class(longint unsigned bytes);
    for (int unsigned c = 0; c < NumClasses; c++)
      if (bytes <= (64'd1 << ShiftOf[c])) return c;
    return NoClass;
  endfunction

  function automatic int unsigned owner_pool(longint unsigned a);
    longint unsigned b;
    for (int unsigned c = 0; c < NumClasses; c++) begin
      b = pool_base(c);
      if (a >= b && a < b + (pool_cap(c) << ShiftOf[c])) return c;
    end
    return NoClass;
  endfunction

  // Pop a freed index, else bump; 0 when the pool is full.
  function automatic bit take_block(int unsigned c, output longint unsigned a);
    int unsigned idx;
    a = 0;
    if (freed_cnt[c] > 0) begin
      freed_cnt[c]--;
      idx = freed_idx[c*MaxBlocks + freed_cnt[c]];
    end else if (bump_idx[c] < pool_cap(c)) begin
      idx = bump_idx[c];
      bump_idx[c]++;
    end else begin
      return 1'b0;
    end
    a = pool_base(c) + (longint'(idx) << ShiftOf[c]);
    return 1'b1;
  endfunction

  // Push the block index; a push onto a full stack is dropped.
  function automatic longint unsigned give_back(int unsigned c, longint unsigned a);
    longint unsigned b;
    longint unsigned idx;
    b = pool_base(c);
    idx = (a - b) >> ShiftOf[c];
    if (freed_cnt[c] < MaxBlocks) begin
      freed_idx[c*MaxBlocks + freed_cnt[c]] = idx[11:0];
      freed_cnt[c]++;
    end
    return b + (idx << ShiftOf[c]);
  endfunction

  function automatic alloc_rsp_t serve(alloc_req_t r);
    alloc_rsp_t o;
    int unsigned rc, oc;
    longint unsigned a, old;
    o = '{status: ST_OK, address: '0, size_class: '0};
    old = r.old_address;
    if (r.cmd == CMD_ALLOC || r.cmd == CMD_REALLOC) begin
      rc = fit_class(r.request_bytes);
      oc = (r.cmd == CMD_REALLOC) ? owner_pool(old) : NoClass;
      if (rc == NoClass) begin
        o.status = ST_TOO_LARGE;
      end else if (oc == rc) begin
        o.status = ST_KEPT;
        o.size_class = ClassW'(rc);
        a = pool_base(oc);
        o.address = AddrW'(a + (((old - a) >> ShiftOf[oc]) << ShiftOf[oc]));
      end else begin
        o.size_class = ClassW'(rc);
        if (!take_block(rc, a)) begin
          o.status = ST_FULL;
        end else begin
          o.address = AddrW'(a);
          if (oc != NoClass) void'(give_back(oc, old));
        end
      end
    end else if (r.cmd == CMD_FREE) begin
      oc = owner_pool(old);
      if (oc == NoClass) begin
        o.status = ST_NOT_IN_POOL;
      end else begin
        o.address = AddrW'(give_back(oc, old));
        o.size_class = ClassW'(oc);
      end
    end
    return o;
  endfunction

  // Predict, queue the transfer, and track granted blocks for later frees.
  task automatic send(alloc_req_t r, int live_pos);
    alloc_rsp_t o;
    o = serve(r);
    expected_q.push_back(o);
    pending_q.push_back(r);
    if (o.status == ST_OK && r.cmd != CMD_NONE) begin
      if (live_pos >= 0 && r.cmd != CMD_ALLOC) granted_q.delete(live_pos);
      if (r.cmd != CMD_FREE) granted_q.push_back(o.address);
    end
  endtask

  task automatic send_op(cmd_e c, longint unsigned bytes, longint unsigned a);
    alloc_req_t r;
    r.cmd = c;
    r.request_bytes = ReqW'(bytes);
    r.old_address = AddrW'(a);
    send(r, -1);
  endtask

  function automatic longint unsigned pick_bytes();
    int unsigned c, p;
    longint unsigned lo, hi;
    p = $urandom_range(99);
    if (p < 5) return 0;
    if (p < 12) return {$urandom()};
    c = $urandom_range(NumClasses - 1);
    hi = 64'd1 << ShiftOf[c];
    lo = (c == 0) ? 1 : (64'd1 << ShiftOf[c-1]) + 1;
    if ($urandom_range(3) == 0) return ($urandom_range(1)) ? hi : lo;
    return lo + ({$urandom(), $urandom()} % (hi - lo + 1));
  endfunction

  // Mostly well-formed traffic on granted blocks, some noise addresses.
  task automatic send_random();
    alloc_req_t r;
    int unsigned p;
    int pos;
    longint unsigned a;
    pos = -1;
    p = $urandom_range(99);
    r.cmd = (p < 45) ? CMD_ALLOC : (p < 78) ? CMD_FREE : (p < 97) ? CMD_REALLOC : CMD_NONE;
    r.request_bytes = ReqW'(pick_bytes());
    if (granted_q.size() > 0 && $urandom_range(9) < 8) begin
      pos = $urandom_range(granted_q.size() - 1);
      a = granted_q[pos];
      if ($urandom_range(1)) a += $urandom_range(1023);
      r.old_address = AddrW'(a);
    end else if ($urandom_range(1)) begin
      r.old_address = AddrW'({$urandom(), $urandom()});
    end else begin
      r.old_address = AddrW'({$urandom()} % (pool_base(NumClasses - 1) + 64'd1));
    end
    send(r, pos);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_pools(int unsigned b0, int unsigned b1, int unsigned b2, int unsigned b3);
    int unsigned v [NumClasses];
    v = '{b0, b1, b2, b3};
    for (int unsigned i = 0; i < NumClasses; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(i);
      cfg_wdata_i <= RegW'(v[i]);
      pool_blocks[i] = RegW'(v[i]);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Driver: a new transfer only once the previous one has gone.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_q.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallMax) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, rsp_ch.data);
        end else begin
          exp_rsp = expected_q.pop_front();
          if (rsp_ch.data.status !== exp_rsp.status) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, exp_rsp.status,
                     rsp_ch.data.status);
          end
          if (rsp_ch.data.address !== exp_rsp.address) begin
            errors++;
            $display("%0t: address exp %h got %h", $time, exp_rsp.address,
                     rsp_ch.data.address);
          end
          if (rsp_ch.data.size_class !== exp_rsp.size_class) begin
            errors++;
            $display("%0t: class exp %0d got %0d", $time, exp_rsp.size_class,
                     rsp_ch.data.size_class);
          end
        end
      end
    end
  end

  initial begin
    int unsigned idle_sel [4][2];
    idle_sel = '{'{0, 0}, '{64, 0}, '{0, 64}, '{7, 7}};
    for (int unsigned i = 0; i < NumClasses; i++) begin
      pool_blocks[i] = '0;
      freed_cnt[i] = 0;
      bump_idx[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: tiny pools so full is reached quickly
    write_pools(2, 1, 1, 1);
    send_op(CMD_ALLOC, 0, 0);                 // zero size goes to 1 KiB
    send_op(CMD_ALLOC, 1024, 0);
    send_op(CMD_ALLOC, 1025, 0);
    send_op(CMD_ALLOC, 1, 0);                 // 1 KiB pool full
    send_op(CMD_ALLOC, 4194304, 0);
    send_op(CMD_ALLOC, 262144, 0);
    send_op(CMD_ALLOC, 4194305, 0);           // too large
    send_op(CMD_ALLOC, 32'hFFFF_FFFF, 0);
    send_op(CMD_FREE, 1024 + 77, 0);          // frees block 0; the size field is ignored
    send_op(CMD_FREE, 0, 0);                  // first block of first pool
    send_op(CMD_FREE, 0, 0);                  // double free
    send_op(CMD_FREE, 35'h7_FFFF_FFFF, 0);    // frees address 0 again; size field ignored
    send_op(CMD_REALLOC, 500, 1024);          // same class, kept
    send_op(CMD_REALLOC, 9000, 0);            // 16 KiB pool already full
    send_op(CMD_REALLOC, 2000, 35'h7_FFFF_FFFF); // outside: plain allocate
    send_op(CMD_REALLOC, 3000, 2048);         // same 16 KiB class, kept
    send_op(CMD_REALLOC, 5000000, 0);         // too large, old kept
    send_op(CMD_NONE, 32'hFFFF_FFFF, 35'h7_FFFF_FFFF);
    send_op(CMD_FREE, 2048, 0);
    wait_idle();

    // Random phases over several pool sizes, each idling mode
    for (int unsigned ph = 0; ph < 8; ph++) begin
      sender_idle_pct = idle_sel[ph % 4][0];
      rx_stall_pct = idle_sel[ph % 4][1];
      granted_q.delete();
      case (ph)
        0:       write_pools(0, 0, 0, 0);
        1:       write_pools(8191, 8191, 8191, 8191);
        2:       write_pools(4096, 3, 0, 4);
        default: write_pools($urandom_range(12), $urandom_range(12),
                             $urandom_range(12), $urandom_range(12));
      endcase
      for (int unsigned n = 0; n < 85; n++) begin
        // Hold-off: one item at a time until the pipe drains
        if (ph == 3 && n < 15) while (expected_q.size() != 0) @(posedge clk_i);
        send_random();
        while (pending_q.size() > 8) @(posedge clk_i);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
